// ----- rtl/bsca_pkg.sv -----
`default_nettype none

package bsca_pkg;

  localparam int RING_BITS  = 64;
  localparam int MAX_LEVELS = 64;
  localparam int DATA_W     = 64;
  localparam int LVL_AW     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int RB_W       = 7;
  localparam int IDX_W      = 6;
  localparam int PLEN_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int HALF_W     = DATA_W / 2;

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_BITS   = 3'd0,
    CFG_PARTY       = 3'd1,
    CFG_CHECK_SCALE = 3'd2,
    CFG_HASH_KEY    = 3'd3,
    CFG_CHALLENGE   = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COEF,
    S_CORR,
    S_MAIN,
    S_TAG,
    S_FIN
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // Mask for ring width w, clamped to 1..RING_BITS.
  function automatic word_t ring_mask(logic [RB_W-1:0] w);
    logic [RB_W-1:0] weff;
    word_t           m;
    weff = w;
    if (weff == '0) weff = RB_W'(1);
    if (weff > RB_W'(RING_BITS)) weff = RB_W'(RING_BITS);
    for (int i = 0; i < DATA_W; i++) begin
      m[i] = (RB_W'(i) < weff);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bsca_if.sv -----
`default_nettype none

interface bsca_in_if import bsca_pkg::*;;
  logic                valid;
  logic                ready;
  logic                func;
  logic [IDX_W-1:0]    table_index;
  word_t               table_word;
  logic [PLEN_W-1:0]   prefix_length;
  word_t               main_value;
  logic                control_bit;
  word_t               tag_value;
  logic                last;

  modport source (
    output valid, func, table_index, table_word, prefix_length,
           main_value, control_bit, tag_value, last,
    input  ready
  );
  modport sink (
    input  valid, func, table_index, table_word, prefix_length,
           main_value, control_bit, tag_value, last,
    output ready
  );
endinterface

interface bsca_out_if import bsca_pkg::*;;
  logic  valid;
  logic  ready;
  word_t check_share;

  modport source (output valid, check_share, input ready);
  modport sink (input valid, check_share, output ready);
endinterface

`default_nettype wire

// ----- rtl/batched_share_check_accumulator.sv -----
// Load transaction: written straight into the level table RAM; accepted only when idle.
// Query transaction: coefficient, main and tag multiplies, plus one for a level correction and one with last.
// Each modular multiply runs on the shared 32x32 multiplier; that unit sets the rate.
// Result is registered once the final multiply is done and the output slot is free.
// Reset (rst_ni, async low): coefficient 1, sums 0, state and config registers to defaults; table not cleared.
`default_nettype none

module batched_share_check_accumulator import bsca_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [DATA_W-1:0]      cfg_wdata_i,
  bsca_in_if.sink               in_i,
  bsca_out_if.source            out_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The ring mask is precomputed at write time.
  // ---------------------------------------------------------------------------
  word_t mask_q;
  logic  party_q;
  word_t scale_q, key_q, chal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= ring_mask(RB_W'(RING_BITS));
      party_q <= 1'b0;
      scale_q <= '0;
      key_q   <= '0;
      chal_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RING_BITS:   mask_q  <= ring_mask(cfg_wdata_i[RB_W-1:0]);
        CFG_PARTY:       party_q <= cfg_wdata_i[0];
        CFG_CHECK_SCALE: scale_q <= cfg_wdata_i;
        CFG_HASH_KEY:    key_q   <= cfg_wdata_i;
        CFG_CHALLENGE:   chal_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input transaction decode
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   wait_q, wait_d;

  logic              in_fire, load_fire, query_fire, mem_we;
  logic [PLEN_W-1:0] plen_m1;
  logic              use_corr;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign load_fire  = in_fire && (func_e'(in_i.func) == FUNC_LOAD);
  assign query_fire = in_fire && (func_e'(in_i.func) == FUNC_QUERY);
  // Slots past the table depth are dropped.
  assign mem_we     = load_fire && ({1'b0, in_i.table_index} < PLEN_W'(MAX_LEVELS));
  assign plen_m1    = in_i.prefix_length - PLEN_W'(1);
  // A zero or oversized prefix length means no correction at all.
  assign use_corr   = in_i.control_bit && (in_i.prefix_length != '0)
                      && (in_i.prefix_length <= PLEN_W'(MAX_LEVELS));

  // ---------------------------------------------------------------------------
  // Level table: single-port-write, registered-read RAM. The read is issued
  // when the query is accepted and consumed in the correction phase.
  // ---------------------------------------------------------------------------
  word_t level_mem [MAX_LEVELS];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) level_mem[in_i.table_index[LVL_AW-1:0]] <= in_i.table_word;
    if (query_fire) rdata_q <= level_mem[plen_m1[LVL_AW-1:0]];
  end

  // Query fields held for the duration of the transaction
  word_t main_q, tag_q;
  logic  use_corr_q, last_q;

  always_ff @(posedge clk_i) begin
    if (query_fire) begin
      main_q     <= in_i.main_value;
      tag_q      <= in_i.tag_value;
      use_corr_q <= use_corr;
      last_q     <= in_i.last;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier. Each phase state first issues a start (wait_q low),
  // then waits for done and folds the product in.
  // ---------------------------------------------------------------------------
  logic      mul_start;
  word_t     mul_a, mul_b, mul_p;
  mul_stat_t mul_st;

  bsca_mul64 u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mul_st),
    .p_o     (mul_p)
  );

  // Accumulation state
  word_t coef_q, coef_d;
  word_t main_sum_q, main_sum_d;
  word_t tag_sum_q, tag_sum_d;
  word_t term_q, term_d;
  logic  out_valid_q, out_valid_d;
  word_t out_data_q, out_data_d;

  logic  phase_done, slot_free, fin_fire;
  word_t corr;

  assign phase_done = (state_q != S_IDLE) && wait_q && mul_st.done;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign fin_fire   = (state_q == S_FIN) && phase_done && slot_free;
  assign corr       = party_q ? (word_t'(0) - mul_p) : mul_p;

  // Next state
  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    case (state_q)
      S_IDLE: begin
        wait_d = 1'b0;
        if (query_fire) state_d = S_COEF;
      end
      default: begin
        if (!wait_q) begin
          wait_d = 1'b1;
        end else if (mul_st.done) begin
          wait_d = 1'b0;
          case (state_q)
            S_COEF: state_d = use_corr_q ? S_CORR : S_MAIN;
            S_CORR: state_d = S_MAIN;
            S_MAIN: state_d = S_TAG;
            S_TAG:  state_d = last_q ? S_FIN : S_IDLE;
            S_FIN: begin
              // Hold the final product until the output register frees up.
              if (slot_free) begin
                state_d = S_IDLE;
              end else begin
                wait_d = 1'b1;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
    endcase
  end

  // Datapath and multiplier control
  always_comb begin
    mul_start   = (state_q != S_IDLE) && !wait_q;
    mul_a       = coef_q;
    mul_b       = chal_q;
    coef_d      = coef_q;
    main_sum_d  = main_sum_q;
    tag_sum_d   = tag_sum_q;
    term_d      = term_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      S_COEF: begin
        mul_a = coef_q;
        mul_b = chal_q;
        if (phase_done) begin
          coef_d = mul_p & mask_q;
          term_d = main_q & mask_q;
        end
      end
      S_CORR: begin
        mul_a = rdata_q;
        mul_b = key_q;
        if (phase_done) term_d = (main_q + corr) & mask_q;
      end
      S_MAIN: begin
        mul_a = coef_q;
        mul_b = term_q;
        if (phase_done) main_sum_d = (main_sum_q + mul_p) & mask_q;
      end
      S_TAG: begin
        mul_a = coef_q;
        mul_b = tag_q;
        if (phase_done) begin
          tag_sum_d = (tag_sum_q + mul_p) & mask_q;
        end
      end
      S_FIN: begin
        mul_a = scale_q;
        mul_b = main_sum_q;
        if (fin_fire) begin
          out_data_d  = (mul_p - tag_sum_q) & mask_q;
          out_valid_d = 1'b1;
          coef_d      = word_t'(1);
          main_sum_d  = '0;
          tag_sum_d   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
      coef_q      <= word_t'(1);
      main_sum_q  <= '0;
      tag_sum_q   <= '0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
      coef_q      <= coef_d;
      main_sum_q  <= main_sum_d;
      tag_sum_q   <= tag_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q     <= term_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.check_share = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_mul_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_st.busy)
    else $error("multiplier restarted while busy");

  a_query_enters_coef: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_fire |=> (state_q == S_COEF) && !wait_q)
    else $error("query transaction did not start coefficient phase");

  a_batch_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire |=> out_o.valid && (coef_q == word_t'(1))
                 && (main_sum_q == '0) && (tag_sum_q == '0))
    else $error("accumulation not restarted after result");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && phase_done && !slot_free)
      |=> (state_q == S_FIN) && $stable(out_o.check_share))
    else $error("final result overwrote a pending output");

endmodule

`default_nettype wire

// ----- rtl/bsca_mul64.sv -----
`default_nettype none

// 64x64 -> low 64 bits over one shared 32x32 multiplier, three partial products in turn.
module bsca_mul64 import bsca_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  input  word_t      a_i,
  input  word_t      b_i,
  output mul_stat_t  stat_o,
  output word_t      p_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [1:0]  step_q, step_d;
  word_t       a_q, b_q;
  word_t       prod_q, prod_d;
  word_t       acc_q, acc_d;
  logic [HALF_W-1:0] x, y;

  always_comb begin
    case (step_q)
      2'd0: begin
        x = a_q[HALF_W-1:0];
        y = b_q[HALF_W-1:0];
      end
      2'd1: begin
        x = a_q[HALF_W-1:0];
        y = b_q[DATA_W-1:HALF_W];
      end
      default: begin
        x = a_q[DATA_W-1:HALF_W];
        y = b_q[HALF_W-1:0];
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    prod_d = prod_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = 2'd0;
    end else if (busy_q) begin
      step_d = step_q + 2'd1;
      if (step_q != 2'd3) prod_d = {{HALF_W{1'b0}}, x} * {{HALF_W{1'b0}}, y};
      case (step_q)
        2'd0: acc_d = acc_q;
        2'd1: acc_d = prod_q;
        default: acc_d = acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
      endcase
      if (step_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign p_o         = acc_q;

endmodule

`default_nettype wire
